// ----- hdl/pulse_width_uart_frame_decoder_assert.svh -----
// Assertion macros for the pulse-width UART frame decoder.
// Needs signals named clk and rst_n in the scope where a macro is used.
`ifndef PULSE_WIDTH_UART_FRAME_DECODER_ASSERT_SVH
`define PULSE_WIDTH_UART_FRAME_DECODER_ASSERT_SVH
`ifndef SYNTHESIS
// Antecedent true implies consequent in the same cycle
`define PWUD_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("pwud: same-cycle check failed");
// Antecedent true implies consequent in the next cycle
`define PWUD_ASSERT_NXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("pwud: next-cycle check failed");
`else
`define PWUD_ASSERT_IMP(lbl, ante, cons)
`define PWUD_ASSERT_NXT(lbl, ante, cons)
`endif
`endif

// ----- hdl/pwud_pkg.sv -----
// Shared types and constants for the pulse-width UART frame decoder.
// No dependencies.
`timescale 1ns / 1ps

package pwud_pkg;

    // frame geometry
    localparam int FRAME_BITS_DEF = 11;
    localparam int CNT_W          = 4;

    // payload widths
    localparam int DUR_W  = 15;
    localparam int BLEN_W = 9;
    localparam int WORD_W = 9;
    localparam logic [WORD_W-1:0] WORD_MASK_MAX = 9'h1FF;
    localparam logic [BLEN_W-1:0] BLEN_RESET    = 9'd50;

    // divider: dividend is duration plus half a bit length
    localparam int DIVD_W = DUR_W + 1;
    localparam int STEP_W = $clog2(DIVD_W);

    // queue between front and back
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

    // configuration port
    localparam int PADDR_W   = 3;
    localparam int PDATA_W   = 32;
    localparam int REG_IDX_W = PADDR_W - 2;
    localparam logic [REG_IDX_W-1:0] REG_BIT_LENGTH = 1'b0;

    // front state machine
    typedef enum logic [1:0] {
        FE_IDLE,
        FE_DIV,
        FE_PUSH
    } fe_state_t;

    // classified pulse handed from front to back
    typedef struct packed {
        logic             restart;
        logic             level;
        logic [CNT_W-1:0] count;
    } pwud_op_t;

    // queue status
    typedef struct packed {
        logic full;
        logic empty;
    } pwud_qstat_t;

endpackage

// ----- hdl/pwud_front.sv -----
// Front part: accepts pulse items and turns the duration into a bit count
// by an iterative restoring divide. Depends on pwud_pkg.
`timescale 1ns / 1ps

module pwud_front #(
    parameter int FRAME_BITS = pwud_pkg::FRAME_BITS_DEF
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         in_valid,
    output logic                         in_ready,
    input  logic                         restart,
    input  logic [pwud_pkg::DUR_W-1:0]   duration,
    input  logic                         level,
    input  logic [pwud_pkg::BLEN_W-1:0]  bit_length,
    output logic                         op_valid,
    input  logic                         op_ready,
    output pwud_pkg::pwud_op_t           op,
    output logic                         busy
);

    localparam logic [pwud_pkg::DIVD_W-1:0] FB_Q = pwud_pkg::DIVD_W'(FRAME_BITS);
    localparam logic [pwud_pkg::STEP_W-1:0] LAST_STEP =
        pwud_pkg::STEP_W'(pwud_pkg::DIVD_W - 1);

    pwud_pkg::fe_state_t state_reg, state_next;

    logic [pwud_pkg::DIVD_W-1:0] dvd_reg, dvd_next;
    logic [pwud_pkg::BLEN_W-1:0] rem_reg, rem_next;
    logic [pwud_pkg::BLEN_W-1:0] dvs_reg, dvs_next;
    logic [pwud_pkg::STEP_W-1:0] step_reg, step_next;
    logic                        restart_reg, restart_next;
    logic                        level_reg, level_next;

    logic                        accept;
    logic [pwud_pkg::BLEN_W:0]   rem_shift;
    logic                        ge;

    assign accept = in_valid && in_ready;

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            pwud_pkg::FE_IDLE:
            begin
                if (in_valid)
                    state_next = pwud_pkg::FE_DIV;
            end
            pwud_pkg::FE_DIV:
            begin
                if (step_reg == LAST_STEP)
                    state_next = pwud_pkg::FE_PUSH;
            end
            pwud_pkg::FE_PUSH:
            begin
                if (op_ready)
                    state_next = pwud_pkg::FE_IDLE;
            end
            default:
                state_next = pwud_pkg::FE_IDLE;
        endcase
    end

    // state outputs
    always_comb
    begin
        in_ready = 1'b0;
        op_valid = 1'b0;
        busy     = 1'b1;
        case (state_reg)
            pwud_pkg::FE_IDLE:
            begin
                in_ready = 1'b1;
                busy     = 1'b0;
            end
            pwud_pkg::FE_DIV:
                busy = 1'b1;
            pwud_pkg::FE_PUSH:
                op_valid = 1'b1;
            default:
                busy = 1'b1;
        endcase
    end

    // one restoring divide step per cycle
    assign rem_shift = {rem_reg, dvd_reg[pwud_pkg::DIVD_W-1]};
    assign ge        = rem_shift >= {1'b0, dvs_reg};

    always_comb
    begin
        dvd_next     = dvd_reg;
        rem_next     = rem_reg;
        dvs_next     = dvs_reg;
        step_next    = step_reg;
        restart_next = restart_reg;
        level_next   = level_reg;
        if (accept)
        begin
            // round to nearest: add half a bit length before dividing
            dvd_next     = {1'b0, duration}
                         + pwud_pkg::DIVD_W'(bit_length >> 1);
            rem_next     = '0;
            dvs_next     = (bit_length == '0) ? pwud_pkg::BLEN_W'(1) : bit_length;
            step_next    = '0;
            restart_next = restart;
            level_next   = level;
        end
        else if (state_reg == pwud_pkg::FE_DIV)
        begin
            rem_next  = ge ? pwud_pkg::BLEN_W'(rem_shift - {1'b0, dvs_reg})
                           : rem_shift[pwud_pkg::BLEN_W-1:0];
            dvd_next  = {dvd_reg[pwud_pkg::DIVD_W-2:0], ge};
            step_next = step_reg + 1'b1;
        end
    end

    // clamp quotient to one frame
    assign op.restart = restart_reg;
    assign op.level   = level_reg;
    assign op.count   = (dvd_reg > FB_Q) ? pwud_pkg::CNT_W'(FRAME_BITS)
                                         : dvd_reg[pwud_pkg::CNT_W-1:0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= pwud_pkg::FE_IDLE;
        else
            state_reg <= state_next;
    end

    // datapath, no reset
    always_ff @(posedge clk)
    begin
        dvd_reg     <= dvd_next;
        rem_reg     <= rem_next;
        dvs_reg     <= dvs_next;
        step_reg    <= step_next;
        restart_reg <= restart_next;
        level_reg   <= level_next;
    end

endmodule

// ----- hdl/pwud_queue.sv -----
// Short queue of classified pulses between front and back.
// Depends on pwud_pkg.
`timescale 1ns / 1ps

module pwud_queue (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  push_valid,
    output logic                  push_ready,
    input  pwud_pkg::pwud_op_t    push_op,
    output logic                  pop_valid,
    input  logic                  pop_ready,
    output pwud_pkg::pwud_op_t    pop_op,
    output pwud_pkg::pwud_qstat_t qstat
);

    localparam logic [pwud_pkg::QPTR_W:0] DEPTH_C =
        (pwud_pkg::QPTR_W + 1)'(pwud_pkg::QUEUE_DEPTH);

    pwud_pkg::pwud_op_t entry_reg [pwud_pkg::QUEUE_DEPTH];

    logic [pwud_pkg::QPTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [pwud_pkg::QPTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [pwud_pkg::QPTR_W:0]   fill_reg, fill_next;
    logic                        push, pop;

    assign qstat.full  = (fill_reg == DEPTH_C);
    assign qstat.empty = (fill_reg == '0);
    assign push_ready  = !qstat.full;
    assign pop_valid   = !qstat.empty;
    assign pop_op      = entry_reg[rd_ptr_reg];
    assign push        = push_valid && push_ready;
    assign pop         = pop_valid && pop_ready;

    // pointer and fill update
    always_comb
    begin
        wr_ptr_next = push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = pop ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        fill_next   = fill_reg;
        if (push && !pop)
            fill_next = fill_reg + 1'b1;
        else if (pop && !push)
            fill_next = fill_reg - 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            fill_reg   <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            fill_reg   <= fill_next;
        end
    end

    // entry storage
    always_ff @(posedge clk)
    begin
        if (push)
            entry_reg[wr_ptr_reg] <= push_op;
    end

endmodule

// ----- hdl/pwud_back.sv -----
// Back part: applies bit counts to the frame being assembled and holds
// the result item in an output register. Depends on pwud_pkg.
`timescale 1ns / 1ps

module pwud_back #(
    parameter int FRAME_BITS = pwud_pkg::FRAME_BITS_DEF
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         op_valid,
    output logic                         op_ready,
    input  pwud_pkg::pwud_op_t           op,
    output logic                         out_valid,
    input  logic                         out_ready,
    output logic [pwud_pkg::WORD_W-1:0]  data_word,
    output logic                         status
);

    localparam int WORD_BITS = (FRAME_BITS - 2 < pwud_pkg::WORD_W) ?
                               FRAME_BITS - 2 : pwud_pkg::WORD_W;
    localparam logic [pwud_pkg::WORD_W-1:0] WORD_MASK =
        pwud_pkg::WORD_W'((1 << WORD_BITS) - 1) & pwud_pkg::WORD_MASK_MAX;
    localparam logic [pwud_pkg::CNT_W-1:0] FB_C = pwud_pkg::CNT_W'(FRAME_BITS);

    logic [pwud_pkg::CNT_W-1:0]  pos_reg, pos_next;
    logic [FRAME_BITS-1:0]       shift_reg, shift_next;
    logic                        out_valid_reg, out_valid_next;
    logic [pwud_pkg::WORD_W-1:0] data_word_reg, data_word_next;
    logic                        status_reg, status_next;

    logic                        take;
    logic [pwud_pkg::CNT_W-1:0]  pos0, room, cnt_eff, k, end_pos;
    logic [FRAME_BITS-1:0]       sh0, sh1, fill_mask, shifted;
    logic                        skip, done;
    logic [pwud_pkg::WORD_W-1:0] word;

    assign op_ready = !out_valid_reg || out_ready;
    assign take     = op_valid && op_ready;

    // bits this pulse adds and where the frame ends up
    always_comb
    begin
        pos0    = op.restart ? '0 : pos_reg;
        sh0     = op.restart ? '0 : shift_reg;
        room    = FB_C - pos0;
        // high pulse rounding to zero fills the rest of the frame
        cnt_eff = (op.count == '0 && op.level) ? room : op.count;
        k       = (cnt_eff < room) ? cnt_eff : room;
        // high level while waiting for a start bit is idle
        skip    = op.level && (pos0 == '0);
        end_pos = pos0 + k;
        for (int i = 0; i < FRAME_BITS; i++)
        begin
            fill_mask[i] = op.level && (pwud_pkg::CNT_W'(i) >= pos0)
                                    && (pwud_pkg::CNT_W'(i) < end_pos);
        end
        sh1     = sh0 | fill_mask;
        done    = !skip && (end_pos == FB_C);
        shifted = sh1 >> 1;
        word    = shifted[pwud_pkg::WORD_W-1:0] & WORD_MASK;
    end

    // frame state and output register
    always_comb
    begin
        pos_next       = pos_reg;
        shift_next     = shift_reg;
        out_valid_next = out_valid_reg && !out_ready;
        data_word_next = data_word_reg;
        status_next    = status_reg;
        if (take)
        begin
            if (skip)
            begin
                pos_next   = pos0;
                shift_next = sh0;
            end
            else if (done)
            begin
                // frame end: a low stop bit is an error
                pos_next       = '0;
                shift_next     = '0;
                out_valid_next = 1'b1;
                data_word_next = op.level ? word : '0;
                status_next    = !op.level;
            end
            else
            begin
                pos_next   = end_pos;
                shift_next = sh1;
            end
        end
    end

    assign out_valid = out_valid_reg;
    assign data_word = data_word_reg;
    assign status    = status_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg       <= '0;
            shift_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            pos_reg       <= pos_next;
            shift_reg     <= shift_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // result payload, no reset
    always_ff @(posedge clk)
    begin
        data_word_reg <= data_word_next;
        status_reg    <= status_next;
    end

endmodule

// ----- hdl/pulse_width_uart_frame_decoder.sv -----
// Top level of the pulse-width UART frame decoder: config register,
// front divider, queue and frame assembler. Depends on pwud_pkg, pwud_front,
// pwud_queue, pwud_back and pulse_width_uart_frame_decoder_assert.svh.
//
//  channel  | handshake            | payload
//  ---------+----------------------+-------------------------------
//  input    | in_valid / in_ready  | restart, duration, level
//  output   | out_valid / out_ready| data_word, status
//  config   | psel/penable/pready  | paddr, pwdata, pwrite, prdata
//
// In the front an item goes through accept, 16 steps of the restoring
// divide by bit_length, then a push into the two-entry queue.
// The back handles one queued item per cycle when its output register is empty or being read.
// Reset clears the frame, the queue, the result valid flag and sets bit_length to 50.
// A stalled output fills the queue, and then the front holds its item.
`timescale 1ns / 1ps
`include "pulse_width_uart_frame_decoder_assert.svh"

module pulse_width_uart_frame_decoder #(
    parameter int FRAME_BITS = pwud_pkg::FRAME_BITS_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic                          restart,
    input  logic [pwud_pkg::DUR_W-1:0]    duration,
    input  logic                          level,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic [pwud_pkg::WORD_W-1:0]   data_word,
    output logic                          status,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [pwud_pkg::PADDR_W-1:0]  paddr,
    input  logic [pwud_pkg::PDATA_W-1:0]  pwdata,
    output logic [pwud_pkg::PDATA_W-1:0]  prdata,
    output logic                          pready
);

    logic [pwud_pkg::BLEN_W-1:0]   bit_length_reg, bit_length_next;
    logic [pwud_pkg::REG_IDX_W-1:0] reg_idx;
    logic                          cfg_write;

    logic                  fe_op_valid, fe_op_ready, fe_busy;
    pwud_pkg::pwud_op_t    fe_op;
    logic                  bk_op_valid, bk_op_ready;
    pwud_pkg::pwud_op_t    bk_op;
    pwud_pkg::pwud_qstat_t qstat;

    // configuration register
    assign pready    = 1'b1;
    assign reg_idx   = paddr[pwud_pkg::PADDR_W-1:2];
    assign cfg_write = psel && penable && pwrite && pready;

    always_comb
    begin
        bit_length_next = bit_length_reg;
        if (cfg_write && reg_idx == pwud_pkg::REG_BIT_LENGTH)
            bit_length_next = pwdata[pwud_pkg::BLEN_W-1:0];
    end

    always_comb
    begin
        prdata = '0;
        if (reg_idx == pwud_pkg::REG_BIT_LENGTH)
            prdata = pwud_pkg::PDATA_W'(bit_length_reg);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            bit_length_reg <= pwud_pkg::BLEN_RESET;
        else
            bit_length_reg <= bit_length_next;
    end

    // front: accept and divide
    pwud_front #(
        .FRAME_BITS (FRAME_BITS)
    ) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .restart    (restart),
        .duration   (duration),
        .level      (level),
        .bit_length (bit_length_reg),
        .op_valid   (fe_op_valid),
        .op_ready   (fe_op_ready),
        .op         (fe_op),
        .busy       (fe_busy)
    );

    // queue between the two parts
    pwud_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (fe_op_valid),
        .push_ready (fe_op_ready),
        .push_op    (fe_op),
        .pop_valid  (bk_op_valid),
        .pop_ready  (bk_op_ready),
        .pop_op     (bk_op),
        .qstat      (qstat)
    );

    // back: frame assembly and result register
    pwud_back #(
        .FRAME_BITS (FRAME_BITS)
    ) u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .op_valid   (bk_op_valid),
        .op_ready   (bk_op_ready),
        .op         (bk_op),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .data_word  (data_word),
        .status     (status)
    );

    // checks
    `PWUD_ASSERT_NXT(a_busy_after_accept, in_valid && in_ready, fe_busy && !in_ready)
    `PWUD_ASSERT_IMP(a_error_word_zero, out_valid && status, data_word == '0)
    `PWUD_ASSERT_IMP(a_no_push_when_full, fe_op_valid && fe_op_ready, !qstat.full)
    `PWUD_ASSERT_IMP(a_pop_needs_entry, bk_op_valid && bk_op_ready, !qstat.empty)

endmodule
